### hdl/cla_pkg.sv
// ----------------------------------------------------------------------------
// cla_pkg: shared types and constants of the line assembler
// Action and result kind codes, controller states, the command and status
// bundles between controller and datapath, and the character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cla_pkg;

    typedef enum logic [1:0] {
        ACT_RX     = 2'd0,
        ACT_READ   = 2'd1,
        ACT_PROMPT = 2'd2,
        ACT_FLUSH  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        K_BYTE   = 3'd0,
        K_NOLINE = 3'd1,
        K_EMPTY  = 3'd2,
        K_PROMPT = 3'd3,
        K_FLUSH  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RX,
        ST_RX_BYTE,
        ST_RD_LEN,
        ST_STREAM,
        ST_SINGLE
    } t_state;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int CNT_W   = 7;
    localparam int MAX_OUT = 64;

    typedef struct packed {
        logic capture;
        logic set_prompt;
        logic cut;
        logic rx_byte;
        logic stream_start;
        logic stream;
        logic load_single;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    is_prompt;
        logic    is_drop;
        logic    need_cut;
        logic    slot_free;
        logic    n_zero;
        logic    out_free;
        logic    stream_done;
    } t_stat;

endpackage

`default_nettype wire

### hdl/cla_ram.sv
// ----------------------------------------------------------------------------
// cla_ram: generic simple dual-port ram
// One write port and one read port with enable; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/cla_ctrl.sv
// ----------------------------------------------------------------------------
// cla_ctrl: sequencing controller of the line assembler
// Takes one item at a time and steps the datapath through receive, line
// read-out and single-result sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire cla_pkg::t_action i_action,
    output logic                  o_in_ready,
    input  wire cla_pkg::t_stat   i_stat,
    output cla_pkg::t_cmd         o_cmd
);

    import cla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action) inside
                        ACT_RX:                n_state = ST_RX;
                        ACT_READ:              n_state = ST_RD_LEN;
                        ACT_PROMPT, ACT_FLUSH: n_state = ST_SINGLE;
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RX: begin
                if (i_stat.is_prompt || i_stat.is_drop) begin
                    n_state = ST_IDLE;
                end else if (i_stat.need_cut) begin
                    n_state = ST_RX_BYTE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RX_BYTE: n_state = ST_IDLE;
            ST_RD_LEN: begin
                if (i_stat.slot_free || i_stat.n_zero) begin
                    n_state = ST_SINGLE;
                end else begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (i_stat.stream_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SINGLE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_RX: begin
                if (i_stat.is_prompt) begin
                    o_cmd.set_prompt = 1'b1;
                end else if (i_stat.is_drop) begin
                    o_cmd = '0;
                end else if (i_stat.need_cut) begin
                    o_cmd.cut = 1'b1;
                end else begin
                    o_cmd.rx_byte = 1'b1;
                end
            end
            ST_RX_BYTE: o_cmd.rx_byte = 1'b1;
            ST_RD_LEN: begin
                o_cmd.stream_start = !(i_stat.slot_free || i_stat.n_zero);
            end
            ST_STREAM: begin
                o_cmd.stream = 1'b1;
                o_cmd.finish = i_stat.stream_done;
            end
            ST_SINGLE: begin
                o_cmd.load_single = i_stat.out_free;
                o_cmd.finish      = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/cla_dp.sv
// ----------------------------------------------------------------------------
// cla_dp: datapath of the line assembler
// Line store and length memories, ring pointers, slot occupancy bits,
// read-out pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_dp #(
    parameter int LINES    = 8,
    parameter int LINE_LEN = 128
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire cla_pkg::t_action          i_action,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic [7:0]                i_max_chars,
    input  wire logic                      i_keep_line,
    input  wire cla_pkg::t_cmd             i_cmd,
    output cla_pkg::t_stat                 o_stat,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [2:0]                     o_kind,
    output logic [7:0]                     o_data_byte,
    output logic                           o_last,
    output logic [cla_pkg::CNT_W-1:0]      o_char_count,
    output logic                           o_prompt_seen
);

    import cla_pkg::*;

    localparam int SW    = $clog2(LINES);
    localparam int PW    = $clog2(LINE_LEN);
    localparam int DEPTH = LINES * LINE_LEN;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [SW-1:0]    LAST_SLOT = SW'(LINES - 1);
    localparam logic [PW-1:0]    CUT_POS   = PW'(LINE_LEN - 1);
    localparam logic [AW-1:0]    LL_A      = AW'(LINE_LEN);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_OUT);

    // captured item
    t_action     r_act;
    logic [7:0]  r_byte;
    logic [7:0]  r_maxc;
    logic        r_keep;
    logic        r_seen;

    // ring state
    logic [SW-1:0]    r_wslot, n_wslot;
    logic [SW-1:0]    r_rslot, n_rslot;
    logic [PW-1:0]    r_wpos, n_wpos;
    logic             r_prompt, n_prompt;
    logic             r_last_cr, n_last_cr;
    logic [LINES-1:0] r_occ, n_occ;

    // read-out pipeline
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] r_emit;
    logic             r_dval;

    // result register
    logic             r_ov;
    t_kind            r_kind;
    logic [7:0]       r_data;
    logic             r_last;
    logic [CNT_W-1:0] r_cnt;
    logic             r_oseen;

    logic [SW-1:0]    w_next_wslot, w_prev_wslot, w_next_rslot, w_byte_slot;
    logic             w_lf_hit, w_occ_w;
    logic [AW-1:0]    w_wbase, w_bbase, w_rbase;
    logic [AW-1:0]    w_cut_addr, w_byte_addr;
    logic             w_st_we;
    logic [AW-1:0]    w_st_waddr, w_st_raddr;
    logic [7:0]       w_st_wdata, w_st_rdata;
    logic             w_len_we;
    logic [PW-1:0]    w_len;
    logic [8:0]       w_len9, w_max9, w_m9, w_n9;
    logic [CNT_W-1:0] w_n;
    logic             w_out_free, w_load_s, w_issue, w_emit_last;
    t_kind            w_single_kind;

    assign w_next_wslot = (r_wslot == LAST_SLOT) ? '0 : SW'(r_wslot + SW'(1));
    assign w_prev_wslot = (r_wslot == '0) ? LAST_SLOT : SW'(r_wslot - SW'(1));
    assign w_next_rslot = (r_rslot == LAST_SLOT) ? '0 : SW'(r_rslot + SW'(1));

    // lf right after a stored cr
    assign w_lf_hit    = (r_byte == CH_LF) && (r_wpos != '0) && r_last_cr;
    // current slot still holds an unread line: overwrite the newest one
    assign w_occ_w     = r_occ[r_wslot];
    assign w_byte_slot = w_occ_w ? w_prev_wslot : r_wslot;

    assign w_wbase     = AW'(AW'(r_wslot) * LL_A);
    assign w_bbase     = AW'(AW'(w_byte_slot) * LL_A);
    assign w_rbase     = AW'(AW'(r_rslot) * LL_A);
    assign w_cut_addr  = AW'(w_wbase + AW'(r_wpos) - AW'(1));
    assign w_byte_addr = AW'(w_bbase + AW'(r_wpos));

    assign w_st_we    = i_cmd.cut || (i_cmd.rx_byte && !w_lf_hit);
    assign w_st_waddr = i_cmd.cut ? w_cut_addr : w_byte_addr;
    assign w_st_wdata = i_cmd.cut ? CH_CR : r_byte;
    assign w_st_raddr = AW'(w_rbase + AW'(r_issue));

    assign w_len_we = i_cmd.cut || (i_cmd.rx_byte && w_lf_hit && (r_wpos != PW'(1)));

    cla_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (w_issue),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    cla_ram #(
        .WIDTH (PW),
        .DEPTH (LINES)
    ) u_len (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (r_wslot),
        .i_wdata (r_wpos),
        .i_re    (1'b1),
        .i_raddr (r_rslot),
        .o_rdata (w_len)
    );

    // characters to deliver: min(max, len) - 1, capped
    assign w_len9 = 9'(w_len);
    assign w_max9 = {1'b0, r_maxc};
    assign w_m9   = (w_max9 < w_len9) ? w_max9 : w_len9;
    assign w_n9   = (w_m9 == '0) ? '0 : 9'(w_m9 - 9'd1);
    assign w_n    = (w_n9 > 9'(MAX_OUT)) ? CNT_MAX : w_n9[CNT_W-1:0];

    assign w_out_free  = !r_ov || i_out_ready;
    assign w_load_s    = i_cmd.stream && r_dval && w_out_free;
    assign w_issue     = i_cmd.stream && (r_issue != r_n) && (!r_dval || w_load_s);
    assign w_emit_last = (CNT_W'(r_emit + CNT_W'(1)) == r_n);

    always_comb begin
        case (r_act)
            ACT_PROMPT: w_single_kind = K_PROMPT;
            ACT_FLUSH:  w_single_kind = K_FLUSH;
            default:    w_single_kind = r_occ[r_rslot] ? K_EMPTY : K_NOLINE;
        endcase
    end

    always_comb begin
        n_wslot   = r_wslot;
        n_wpos    = r_wpos;
        n_rslot   = r_rslot;
        n_prompt  = r_prompt;
        n_last_cr = r_last_cr;
        n_occ     = r_occ;
        if (i_cmd.set_prompt) begin
            n_prompt = 1'b1;
        end
        // line reached its limit: close it with a cr over its last stored byte
        if (i_cmd.cut) begin
            n_occ[r_wslot] = 1'b1;
            n_wpos         = '0;
            n_wslot        = w_next_wslot;
            n_last_cr      = 1'b0;
        end
        if (i_cmd.rx_byte) begin
            if (w_lf_hit) begin
                if (r_wpos == PW'(1)) begin
                    n_wpos = '0;
                end else begin
                    n_occ[r_wslot] = 1'b1;
                    n_wpos         = '0;
                    n_wslot        = w_next_wslot;
                end
                n_last_cr = 1'b0;
            end else begin
                if (w_occ_w) begin
                    n_occ[w_prev_wslot] = 1'b0;
                end
                n_wslot   = w_byte_slot;
                n_wpos    = PW'(r_wpos + PW'(1));
                n_last_cr = (r_byte == CH_CR);
            end
        end
        if (i_cmd.finish) begin
            case (r_act)
                ACT_PROMPT: n_prompt = 1'b0;
                ACT_FLUSH: begin
                    n_occ     = '0;
                    n_wslot   = '0;
                    n_wpos    = '0;
                    n_rslot   = '0;
                    n_prompt  = 1'b0;
                    n_last_cr = 1'b0;
                end
                ACT_READ: begin
                    if (!r_keep && r_occ[r_rslot]) begin
                        n_occ[r_rslot] = 1'b0;
                        n_rslot        = w_next_rslot;
                    end
                end
                default: n_prompt = r_prompt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot   <= '0;
            r_wpos    <= '0;
            r_rslot   <= '0;
            r_prompt  <= 1'b0;
            r_last_cr <= 1'b0;
            r_occ     <= '0;
        end else begin
            r_wslot   <= n_wslot;
            r_wpos    <= n_wpos;
            r_rslot   <= n_rslot;
            r_prompt  <= n_prompt;
            r_last_cr <= n_last_cr;
            r_occ     <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_byte <= i_rx_byte;
            r_maxc <= i_max_chars;
            r_keep <= i_keep_line;
            r_seen <= r_prompt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stream_start) begin
            r_n     <= w_n;
            r_issue <= '0;
            r_emit  <= '0;
        end else begin
            if (w_issue) begin
                r_issue <= CNT_W'(r_issue + CNT_W'(1));
            end
            if (w_load_s) begin
                r_emit <= CNT_W'(r_emit + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dval <= 1'b0;
        end else if (i_cmd.stream_start) begin
            r_dval <= 1'b0;
        end else if (w_issue) begin
            r_dval <= 1'b1;
        end else if (w_load_s) begin
            r_dval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_single || w_load_s) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_kind  <= w_single_kind;
            r_data  <= '0;
            r_last  <= 1'b1;
            r_cnt   <= '0;
            r_oseen <= r_seen;
        end else if (w_load_s) begin
            r_kind  <= K_BYTE;
            r_data  <= w_st_rdata;
            r_last  <= w_emit_last;
            r_cnt   <= r_n;
            r_oseen <= r_seen;
        end
    end

    always_comb begin
        o_stat.act         = r_act;
        o_stat.is_prompt   = (r_byte == CH_PROMPT);
        o_stat.is_drop     = (r_byte == CH_SPACE) && (r_wpos == '0);
        o_stat.need_cut    = (r_wpos >= CUT_POS);
        o_stat.slot_free   = !r_occ[r_rslot];
        o_stat.n_zero      = (w_n9 == '0);
        o_stat.out_free    = w_out_free;
        o_stat.stream_done = w_load_s && w_emit_last;
    end

    assign o_out_valid   = r_ov;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_last        = r_last;
    assign o_char_count  = r_cnt;
    assign o_prompt_seen = r_oseen;

endmodule

`default_nettype wire

### hdl/crlf_line_assembler_ring.sv
// ----------------------------------------------------------------------------
// crlf_line_assembler_ring: uart receive line assembler with a ring of lines
// Gathers received bytes into line slots closed by cr lf, and reads lines out
// byte by byte; also prompt flag read-and-clear and ring flush.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready with action, byte, reader size and
// peek flag. Output channel: o_out_valid / i_out_ready, one result item per
// transfer; o_last marks the final result of an item.
// One item is worked on at a time. A received byte keeps the block busy in
// a receive state, plus a second byte state when a full line is cut first,
// and gives no result. Prompt and flush give one result, loaded into the
// output register once it is free. A line read looks up the length, then
// streams the line store at one byte per cycle while the receiver keeps up;
// each byte passes the registered read port of the line store before it
// reaches the output register.
// The result sits in an output register, so the next item is taken while the
// last result still waits. A stalled receiver holds the read-out stream in
// place without loss. Reset empties the ring and clears the prompt flag at
// once; line store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_line_assembler_ring #(
    parameter int LINES    = 8,
    parameter int LINE_LEN = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_max_chars,
    input  wire logic       i_keep_line,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_last,
    output logic [6:0]      o_char_count,
    output logic            o_prompt_seen
);

    import cla_pkg::*;

    t_action w_action;
    t_cmd    w_cmd;
    t_stat   w_stat;

    assign w_action = t_action'(i_action);

    cla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (w_action),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cla_dp #(
        .LINES    (LINES),
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (w_action),
        .i_rx_byte     (i_rx_byte),
        .i_max_chars   (i_max_chars),
        .i_keep_line   (i_keep_line),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last),
        .o_char_count  (o_char_count),
        .o_prompt_seen (o_prompt_seen)
    );

    // end of a line stream shows up as a last line byte
    a_stream_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.stream_done |=> o_out_valid && o_last && (o_kind == K_BYTE))
        else $error("stream end did not present a last line byte");

    // single results are never line bytes and always close the item
    a_single_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_single |=> o_out_valid && o_last && (o_kind != K_BYTE))
        else $error("single result malformed");

    // a line byte carries a nonzero, capped count
    a_byte_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == K_BYTE))
            |-> (o_char_count != 7'd0) && (o_char_count <= 7'(MAX_OUT)))
        else $error("line byte with bad char count");

    // no new item taken while a line is streaming
    a_busy_stream : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.stream |-> !o_in_ready)
        else $error("input ready during read-out");

endmodule

`default_nettype wire

### tb/sv/cla_line_checker.sv
// ----------------------------------------------------------------------------
// cla_line_checker: result predictor and scoreboard for the line assembler
// Watches both channels, keeps its own copy of the line ring and prompt flag,
// works out the results of every accepted item, and compares each accepted
// result field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_line_checker #(
    parameter int LINES    = 8,
    parameter int LINE_LEN = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_max_chars,
    input  wire logic       i_keep_line,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [2:0] i_kind,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    input  wire logic [6:0] i_char_count,
    input  wire logic       i_prompt_seen,
    output int              o_fail_count,
    output int              o_pending
);

    import cla_pkg::*;

    localparam int SLOT_W = $clog2(LINES);
    localparam int POS_W  = $clog2(LINE_LEN);

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] count;
        logic       seen;
    } t_line_result;

    t_line_result      awaited_q[$];
    logic [7:0]        slot_text [LINES][LINE_LEN];
    logic [POS_W-1:0]  slot_len  [LINES];
    logic [SLOT_W-1:0] wr_slot;
    logic [POS_W-1:0]  wr_pos;
    logic [SLOT_W-1:0] rd_slot;
    logic              prompt_q;
    int                mismatch_total;
    int                result_idx;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_total++;
    endtask

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(LINES - 1)) ? '0 : s + 1'b1;
    endfunction

    task automatic await_result(input t_kind kind, input logic [7:0] data,
                                input logic last, input logic [6:0] count,
                                input logic seen);
        t_line_result r;
        r.kind  = kind;
        r.data  = data;
        r.last  = last;
        r.count = count;
        r.seen  = seen;
        awaited_q.push_back(r);
    endtask

    // the cr lands on the last stored byte, then the write moves on
    task automatic close_line();
        slot_text[wr_slot][wr_pos - 1'b1] = CH_CR;
        slot_len[wr_slot] = wr_pos;
        wr_pos  = '0;
        wr_slot = slot_after(wr_slot);
    endtask

    task automatic take_byte(input logic [7:0] b);
        if (b == CH_PROMPT) begin
            prompt_q = 1'b1;
        end else if (!(b == CH_SPACE && wr_pos == 0)) begin
            if (wr_pos >= LINE_LEN - 1) close_line();
            if (b == CH_LF && wr_pos != 0 && slot_text[wr_slot][wr_pos - 1'b1] == CH_CR) begin
                if (wr_pos == 1) wr_pos = '0;
                else close_line();
            end else begin
                // ring full: step back and overwrite the newest line
                if (slot_len[wr_slot] != 0) begin
                    wr_slot = (wr_slot == 0) ? SLOT_W'(LINES - 1) : wr_slot - 1'b1;
                    slot_len[wr_slot] = '0;
                end
                slot_text[wr_slot][wr_pos] = b;
                wr_pos = wr_pos + 1'b1;
            end
        end
    endtask

    task automatic predict_line_item(input t_action act, input logic [7:0] b,
                                     input logic [7:0] maxc, input logic keep);
        logic seen;
        int   len;
        int   n;
        seen = prompt_q;
        case (act)
            ACT_RX: take_byte(b);
            ACT_PROMPT: begin
                await_result(K_PROMPT, 8'h00, 1'b1, 7'd0, seen);
                prompt_q = 1'b0;
            end
            ACT_FLUSH: begin
                foreach (slot_len[s]) slot_len[s] = '0;
                wr_slot  = '0;
                wr_pos   = '0;
                rd_slot  = '0;
                prompt_q = 1'b0;
                await_result(K_FLUSH, 8'h00, 1'b1, 7'd0, seen);
            end
            default: begin
                len = slot_len[rd_slot];
                if (len == 0) begin
                    await_result(K_NOLINE, 8'h00, 1'b1, 7'd0, seen);
                end else begin
                    n = ((int'(maxc) < len) ? int'(maxc) : len) - 1;
                    if (n < 0) n = 0;
                    if (n > MAX_OUT) n = MAX_OUT;
                    if (n == 0) begin
                        await_result(K_EMPTY, 8'h00, 1'b1, 7'd0, seen);
                    end else begin
                        for (int i = 0; i < n; i++)
                            await_result(K_BYTE, slot_text[rd_slot][i], i == n - 1,
                                         7'(n), seen);
                    end
                    if (!keep) begin
                        slot_len[rd_slot] = '0;
                        rd_slot = slot_after(rd_slot);
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            awaited_q.delete();
            foreach (slot_len[s]) slot_len[s] = '0;
            wr_slot        = '0;
            wr_pos         = '0;
            rd_slot        = '0;
            prompt_q       = 1'b0;
            mismatch_total = 0;
            result_idx     = 0;
        end else begin
            // results first: one accepted at this edge belongs to an older item
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d kind %0d with nothing awaited",
                                              result_idx, i_kind));
                end else begin
                    want = awaited_q.pop_front();
                    if (i_kind !== want.kind)
                        report_mismatch($sformatf("result %0d kind got %0d want %0d",
                                                  result_idx, i_kind, want.kind));
                    if (i_data_byte !== want.data)
                        report_mismatch($sformatf("result %0d data_byte got %0h want %0h",
                                                  result_idx, i_data_byte, want.data));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("result %0d last got %0b want %0b",
                                                  result_idx, i_last, want.last));
                    if (i_char_count !== want.count)
                        report_mismatch($sformatf("result %0d char_count got %0d want %0d",
                                                  result_idx, i_char_count, want.count));
                    if (i_prompt_seen !== want.seen)
                        report_mismatch($sformatf("result %0d prompt_seen got %0b want %0b",
                                                  result_idx, i_prompt_seen, want.seen));
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready)
                predict_line_item(t_action'(i_action), i_rx_byte, i_max_chars, i_keep_line);
        end
        o_pending <= awaited_q.size();
    end

endmodule

`default_nettype wire

### tb/sv/tb_crlf_line_assembler_ring.sv
// ----------------------------------------------------------------------------
// tb_crlf_line_assembler_ring: regression bench for the line assembler
// A directed opening covers prompt handling, dropped leading spaces, lone
// cr lf, peeks and short reader buffers, extreme bytes and flush; random
// traffic follows with lines of random content, long and cut lines, a full
// ring, reads, prompts, flushes and noise. Both sides idle at random, and the
// receiver holds off once for a long stretch. Checking is done by the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_crlf_line_assembler_ring;
    import cla_pkg::*;

    localparam int LINES        = 8;
    localparam int LINE_LEN     = 128;
    localparam int RANDOM_ITEMS = 130;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_action;
    logic [7:0] i_rx_byte;
    logic [7:0] i_max_chars;
    logic       i_keep_line;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [2:0] o_kind;
    logic [7:0] o_data_byte;
    logic       o_last;
    logic [6:0] o_char_count;
    logic       o_prompt_seen;

    int fail_count;
    int pending;
    int items_sent;
    bit steady;
    bit hold_req;

    crlf_line_assembler_ring #(
        .LINES    (LINES),
        .LINE_LEN (LINE_LEN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_rx_byte     (i_rx_byte),
        .i_max_chars   (i_max_chars),
        .i_keep_line   (i_keep_line),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_last        (o_last),
        .o_char_count  (o_char_count),
        .o_prompt_seen (o_prompt_seen)
    );

    cla_line_checker #(
        .LINES    (LINES),
        .LINE_LEN (LINE_LEN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_rx_byte     (i_rx_byte),
        .i_max_chars   (i_max_chars),
        .i_keep_line   (i_keep_line),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_kind        (o_kind),
        .i_data_byte   (o_data_byte),
        .i_last        (o_last),
        .i_char_count  (o_char_count),
        .i_prompt_seen (o_prompt_seen),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 24);
            end
        end
    end

    // ends the run when no transfer happens on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        do begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end while (quiet < QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // entered and left at a falling edge; valid holds until the transfer
    task automatic offer(input t_action act, input logic [7:0] b,
                         input logic [7:0] maxc, input logic keep);
        while (!steady && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_rx_byte   <= b;
        i_max_chars <= maxc;
        i_keep_line <= keep;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_line(input int len, input bit plain, input bit terminate);
        logic [7:0] c;
        int         r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (plain || r < 70) begin
                c = 8'($urandom_range(8'h21, 8'h7E));
                if (plain && c == CH_PROMPT) c = 8'h41;
            end else if (r < 80) c = CH_SPACE;
            else if (r < 85) c = CH_CR;
            else if (r < 88) c = CH_PROMPT;
            else c = 8'($urandom);
            offer(ACT_RX, c, 8'($urandom), 1'($urandom));
        end
        if (terminate) begin
            offer(ACT_RX, CH_CR, 8'($urandom), 1'($urandom));
            offer(ACT_RX, CH_LF, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int         target;
        int         ep;
        int         sel;
        int         len;
        logic [7:0] maxc;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_RX;
        i_rx_byte   = 8'h00;
        i_max_chars = 8'h00;
        i_keep_line = 1'b0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        items_sent  = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        offer(ACT_READ,   8'h00,     8'd128, 1'b0);   // nothing ready yet
        offer(ACT_PROMPT, 8'h00,     8'd0,   1'b0);
        offer(ACT_RX,     CH_PROMPT, 8'd0,   1'b0);
        offer(ACT_PROMPT, 8'hFF,     8'hFF,  1'b1);
        offer(ACT_RX,     CH_SPACE,  8'd1,   1'b0);   // leading space dropped
        offer(ACT_RX,     8'h41,     8'd1,   1'b0);
        offer(ACT_RX,     CH_SPACE,  8'd1,   1'b0);
        offer(ACT_RX,     CH_CR,     8'd1,   1'b0);
        offer(ACT_RX,     CH_LF,     8'd1,   1'b0);
        offer(ACT_RX,     CH_CR,     8'd1,   1'b0);   // lone cr lf discarded
        offer(ACT_RX,     CH_LF,     8'd1,   1'b0);
        offer(ACT_READ,   8'h00,     8'd0,   1'b1);   // peeks, short buffers
        offer(ACT_READ,   8'h00,     8'd1,   1'b1);
        offer(ACT_READ,   8'h00,     8'hFF,  1'b1);
        offer(ACT_READ,   8'h00,     8'd2,   1'b0);
        offer(ACT_READ,   8'h00,     8'd128, 1'b0);
        offer(ACT_RX,     8'hFF,     8'd0,   1'b0);
        offer(ACT_RX,     8'h00,     8'd0,   1'b0);
        offer(ACT_RX,     CH_CR,     8'd0,   1'b0);
        offer(ACT_RX,     CH_LF,     8'd0,   1'b0);
        offer(ACT_RX,     CH_PROMPT, 8'd0,   1'b0);
        offer(ACT_FLUSH,  8'h00,     8'd0,   1'b0);   // drops the line and prompt
        offer(ACT_READ,   8'h00,     8'hFF,  1'b0);

        // random traffic
        target = items_sent + RANDOM_ITEMS;
        ep     = 0;
        while (items_sent < target || ep < 26) begin
            ep++;
            steady = (ep >= 10 && ep < 20);
            sel    = $urandom_range(99);
            if (ep >= 12 && ep < 24) sel = 0;          // fill the ring past full
            maxc = ($urandom_range(99) < 70) ? 8'($urandom_range(2, 128)) : 8'($urandom);
            if (ep == 2 || ep == 8) begin
                len = (ep == 2) ? $urandom_range(LINE_LEN - 1, LINE_LEN + 12)
                                : $urandom_range(66, 100);
                send_line(len, 1'b1, 1'b1);
                target += len + 2;
            end else if (ep == 4) begin
                hold_req = 1'b1;
                send_line($urandom_range(2, 10), 1'b1, 1'b1);
                offer(ACT_READ, 8'($urandom), 8'd128, 1'b0);
                send_line($urandom_range(0, 6), 1'b0, 1'b1);
                offer(ACT_READ, 8'($urandom), 8'd128, 1'b1);
            end else if (sel < 45) begin
                send_line($urandom_range(0, 10), 1'b0, $urandom_range(99) >= 15);
            end else if (sel < 72) begin
                offer(ACT_READ, 8'($urandom), maxc, $urandom_range(3) == 0);
            end else if (sel < 80) begin
                offer(ACT_PROMPT, 8'($urandom), 8'($urandom), 1'($urandom));
            end else if (sel < 83) begin
                offer(ACT_FLUSH, 8'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                offer(ACT_RX, 8'($urandom), 8'($urandom), 1'($urandom));
            end
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hdl/cla_pkg.sv
hdl/cla_ram.sv
hdl/cla_ctrl.sv
hdl/cla_dp.sv
hdl/crlf_line_assembler_ring.sv
tb/sv/cla_line_checker.sv
tb/sv/tb_crlf_line_assembler_ring.sv
